[rtl/lpht_pkg.sv]
// Shared types and codes for the linear probe hash table.
package lpht_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  localparam int HASH_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int SIZE_BITS  = 9;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request, start remainder unit
    logic probe_init;  // slot index from remainder, clear step count
    logic rd;          // read slot at index
    logic advance;     // next slot, wrapping at size
    logic commit;      // finish the transaction, raise done
    logic found;       // with commit: probe stopped at a slot
    logic clr_wr;      // clearing pass: zero one entry
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_done;
    logic nop;         // latched operation is not defined
    logic hit;         // read slot is empty or holds the key
    logic last_step;   // probe has covered the whole table
    logic clr_last;
  } dp_sts_t;

endpackage

[rtl/lpht_ram.sv]
// Generic simple dual-port RAM with registered read.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lpht_rem.sv]
// Iterative remainder unit: hash modulo table size, one bit per cycle.
module lpht_rem
  import lpht_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [HASH_BITS-1:0]        dividend,
  input  logic [$clog2(SLOTS+1)-1:0]  divisor,
  output logic                        done,
  output logic [$clog2(SLOTS)-1:0]    rem
);

  localparam int SW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(HASH_BITS + 1);

  logic [CW-1:0]        cnt;
  logic [HASH_BITS-1:0] q;
  logic [SW-1:0]        r;
  logic [SW-1:0]        d;
  logic [SW:0]          trial;
  logic [SW:0]          r_next;

  always_comb begin
    trial  = {r, q[HASH_BITS-1]};
    r_next = (trial >= {1'b0, d}) ? trial - {1'b0, d} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(HASH_BITS);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (cnt != '0) begin
      q <= {q[HASH_BITS-2:0], 1'b0};
      r <= r_next[SW-1:0];  // always below the divisor
    end
  end

  assign done = (cnt == '0);
  assign rem  = AW'(r);

endmodule

[rtl/lpht_dp.sv]
// Datapath: request latch, size register, probe index, slot store, results.
module lpht_dp
  import lpht_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  input  logic                  table_size_we,
  input  logic [SIZE_BITS-1:0]  table_size,
  input  logic [1:0]            func,
  input  logic [FIELD_BITS-1:0] key_in,
  input  logic [HASH_BITS-1:0]  hash_value,
  input  logic [FIELD_BITS-1:0] data_in,
  output logic                  done,
  output logic                  success,
  output logic [FIELD_BITS-1:0] data_out,
  output logic [SIZE_BITS-1:0]  entry_count
);

  localparam int SW   = $clog2(SLOTS + 1);
  localparam int AW   = $clog2(SLOTS);
  localparam int CMPW = (SW > SIZE_BITS) ? SW : SIZE_BITS;
  localparam int WW   = 1 + KEY_BITS + DATA_BITS;

  logic [SIZE_BITS-1:0] size_reg;
  logic [CMPW-1:0]      size_ext;
  logic [CMPW-1:0]      size_clamp;
  logic [SW-1:0]        size;

  func_t                func_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] data_r;

  logic [AW-1:0]        idx;
  logic [SW-1:0]        steps;
  logic [AW-1:0]        clr_addr;
  logic [SW-1:0]        count;
  logic [AW-1:0]        rem;
  logic                 rem_done;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WW-1:0]        ram_wdata;
  logic [WW-1:0]        ram_rdata;

  logic                 slot_used;
  logic [KEY_BITS-1:0]  slot_key;
  logic [DATA_BITS-1:0] slot_data;

  // table size in use: zero means one, above SLOTS saturates
  always_comb begin
    size_ext = CMPW'(size_reg);
    if (size_ext == '0) begin
      size_clamp = CMPW'(1);
    end else if (size_ext > CMPW'(SLOTS)) begin
      size_clamp = CMPW'(SLOTS);
    end else begin
      size_clamp = size_ext;
    end
    size = SW'(size_clamp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (table_size_we) begin
      size_reg <= table_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(func);
      key_r  <= KEY_BITS'(key_in);
      data_r <= DATA_BITS'(data_in);
    end
  end

  lpht_rem #(
    .SLOTS(SLOTS)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load),
    .dividend(hash_value),
    .divisor (size),
    .done    (rem_done),
    .rem     (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      idx   <= rem;
      steps <= '0;
    end else if (cmd.advance) begin
      idx   <= (SW'(idx) == size - SW'(1)) ? '0 : idx + AW'(1);
      steps <= steps + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign {slot_used, slot_key, slot_data} = ram_rdata;

  // store writes: clearing pass, insert into empty slot, remove
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (cmd.commit && cmd.found) begin
      if (func_r == FUNC_INSERT && !slot_used) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, key_r, data_r};
      end else if (func_r == FUNC_REMOVE && slot_used) begin
        ram_we    = 1'b1;
      end
    end
  end

  lpht_ram #(
    .WIDTH(WW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      done    <= 1'b0;
      success <= 1'b0;
    end else begin
      done    <= cmd.commit;
      success <= 1'b0;
      if (cmd.commit && cmd.found) begin
        case (func_r)
          FUNC_INSERT: begin
            if (!slot_used) begin
              success <= 1'b1;
              count   <= count + SW'(1);
            end
          end
          FUNC_REMOVE: begin
            if (slot_used) begin
              success <= 1'b1;
              if (count != '0) begin
                count <= count - SW'(1);
              end
            end
          end
          FUNC_GET: begin
            success <= slot_used;
          end
          default: begin
            success <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      data_out <= '0;
      if (cmd.found && slot_used &&
          (func_r == FUNC_REMOVE || func_r == FUNC_GET)) begin
        data_out <= FIELD_BITS'(slot_data);
      end
    end
  end

  assign entry_count = SIZE_BITS'(count);

  always_comb begin
    sts.rem_done  = rem_done;
    sts.nop       = (func_r == FUNC_NOP);
    sts.hit       = !slot_used || (slot_key == key_r);
    sts.last_step = (steps == size - SW'(1));
    sts.clr_last  = (clr_addr == AW'(SLOTS - 1));
  end

endmodule

[rtl/lpht_ctrl.sv]
// Controller: clearing pass, remainder wait, probe walk, commit.
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.nop) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.rem_done) begin
          cmd.probe_init = 1'b1;
          state_next     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.hit) begin
          cmd.commit = 1'b1;
          cmd.found  = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.last_step) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

[rtl/linear_probe_hash_table_core.sv]
// Top level of the open-addressing hash table with linear probing.
//
//  channel   direction  handshake                  payload
//  request   in         start & !busy              func, key_in, hash_value, data_in
//  result    out        done (one cycle)           success, data_out, entry_count
//  config    in         table_size_we              table_size
//
// Flow: a request waits for the bit-serial hash remainder, then each slot
// probed takes one RAM read and one compare; done is registered from the
// commit of the final compare. The bit-serial remainder unit and the single
// RAM read port set the pace. func 3 answers without the remainder or a
// probe.
// Reset: synchronous, active high; afterwards busy stays high while the
// slot store is swept to zero.
// Stalls: the receiver cannot stall; a result is valid on the ports in the
// one cycle that done is high. Write table_size only while idle.
module linear_probe_hash_table_core
  import lpht_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // request transaction
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [FIELD_BITS-1:0] key_in,
  input  logic [HASH_BITS-1:0]  hash_value,
  input  logic [FIELD_BITS-1:0] data_in,
  // configuration
  input  logic                  table_size_we,
  input  logic [SIZE_BITS-1:0]  table_size,
  // result transaction
  output logic                  done,
  output logic                  success,
  output logic [FIELD_BITS-1:0] data_out,
  output logic [SIZE_BITS-1:0]  entry_count
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencing: clear sweep, remainder wait, read/compare walk
  lpht_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  // storage, remainder unit, probe index and result registers
  lpht_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS),
    .DATA_BITS(DATA_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .table_size_we(table_size_we),
    .table_size   (table_size),
    .func         (func),
    .key_in       (key_in),
    .hash_value   (hash_value),
    .data_in      (data_in),
    .done         (done),
    .success      (success),
    .data_out     (data_out),
    .entry_count  (entry_count)
  );

  // a result only comes out of a transaction in flight
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a transaction in flight");

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a request");

  // the live count moves only with a reported result
  a_count_with_done: assert property (@(posedge clk) disable iff (rst)
    (entry_count != $past(entry_count)) |-> done)
    else $error("entry count changed without a result");

  // a commit and a clearing write never coincide
  a_commit_not_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && cmd.clr_wr))
    else $error("commit during clearing pass");

endmodule

[sim/lpht_checker.sv]
// Checker for the hash table core: shadow table, result prediction and comparison.
module lpht_checker
  import lpht_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            func,
  input  logic [FIELD_BITS-1:0] key_in,
  input  logic [HASH_BITS-1:0]  hash_value,
  input  logic [FIELD_BITS-1:0] data_in,
  input  logic                  table_size_we,
  input  logic [SIZE_BITS-1:0]  table_size,
  input  logic                  done,
  input  logic                  success,
  input  logic [FIELD_BITS-1:0] data_out,
  input  logic [SIZE_BITS-1:0]  entry_count,
  output int                    fails,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  success;
    logic [FIELD_BITS-1:0] data;
    logic [SIZE_BITS-1:0]  count;
  } lookup_result_t;

  // shadow of the slot store
  logic                  shadow_used [SLOTS];
  logic [FIELD_BITS-1:0] shadow_key  [SLOTS];
  logic [FIELD_BITS-1:0] shadow_data [SLOTS];
  logic [SIZE_BITS-1:0]  live_count;
  logic [SIZE_BITS-1:0]  size_reg;

  lookup_result_t lookup_q[$];
  int             mismatches;

  function automatic lookup_result_t apply_request(input func_t op,
                                                   input logic [FIELD_BITS-1:0] key,
                                                   input logic [HASH_BITS-1:0] hash,
                                                   input logic [FIELD_BITS-1:0] data);
    lookup_result_t res;
    int unsigned    span;
    int unsigned    idx;
    int unsigned    n;
    int             stop;
    res = '0;
    stop = -1;
    span = (size_reg == 0) ? 1 : (size_reg > SLOTS) ? SLOTS : size_reg;
    if (op != FUNC_NOP) begin
      idx = hash % span;
      for (n = 0; n < span && stop < 0; n++) begin
        if (!shadow_used[idx] || shadow_key[idx] == key) stop = idx;
        else idx = (idx + 1 == span) ? 0 : idx + 1;
      end
      if (stop >= 0) begin
        if (op == FUNC_INSERT) begin
          if (!shadow_used[stop]) begin
            shadow_used[stop] = 1'b1;
            shadow_key[stop]  = key;
            shadow_data[stop] = data;
            live_count++;
            res.success = 1'b1;
          end
        end else if (shadow_used[stop]) begin
          res.data    = shadow_data[stop];
          res.success = 1'b1;
          if (op == FUNC_REMOVE) begin
            shadow_used[stop] = 1'b0;
            shadow_key[stop]  = '0;
            shadow_data[stop] = '0;
            if (live_count > 0) live_count--;
          end
        end
      end
    end
    res.count = live_count;
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_used[i] = 1'b0;
        shadow_key[i]  = '0;
        shadow_data[i] = '0;
      end
      live_count = '0;
      size_reg   = SIZE_RESET;
      mismatches = 0;
      lookup_q.delete();
    end else begin
      if (table_size_we) size_reg = table_size;
      // result first: it belongs to an earlier transaction
      if (done) begin
        if (lookup_q.size() == 0) begin
          $display("%0t: unexpected result success=%0b data=%h count=%0d",
                   $time, success, data_out, entry_count);
          mismatches++;
        end else begin
          want = lookup_q.pop_front();
          if (success !== want.success) begin
            $display("%0t: success expected %0b actual %0b", $time, want.success, success);
            mismatches++;
          end
          if (data_out !== want.data) begin
            $display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
            mismatches++;
          end
          if (entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, entry_count);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        lookup_q.push_back(apply_request(func_t'(func), key_in, hash_value, data_in));
    end
    fails   <= mismatches;
    pending <= lookup_q.size();
  end

endmodule

[sim/testbench.sv]
// Top of the hash table testbench: clock, reset, request stimulus and verdict.
module testbench
  import lpht_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 256;
  // Worst correct run: ~1650 transactions, each at most a probe of the whole
  // table plus a sender gap, plus the reset sweep. Taken about four times over.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int POOL = 12;          // keys live per random phase
  localparam int PER_PHASE = 133;    // random transactions per table size
  localparam int NUM_PHASES = 12;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  func_t                 func;
  logic [FIELD_BITS-1:0] key_in;
  logic [HASH_BITS-1:0]  hash_value;
  logic [FIELD_BITS-1:0] data_in;
  logic                  table_size_we;
  logic [SIZE_BITS-1:0]  table_size;
  logic                  done;
  logic                  success;
  logic [FIELD_BITS-1:0] data_out;
  logic [SIZE_BITS-1:0]  entry_count;

  int fails;
  int pending;

  int unsigned cycle_count = 0;
  int          gap_pct;        // chance of a sender gap after each transaction
  int          n_sent;
  int          n_nop;
  int          n_sizes;

  // per-phase key set; each key keeps its own hash, as a real requester would
  logic [FIELD_BITS-1:0] pool_key  [POOL];
  logic [HASH_BITS-1:0]  pool_hash [POOL];

  // table sizes for the random phases: tiny, odd, exact, zero and oversized
  logic [SIZE_BITS-1:0] phase_size [NUM_PHASES] =
    '{9'd13, 9'd1, 9'd256, 9'd5, 9'd0, 9'd64, 9'd2, 9'd511, 9'd31, 9'd3, 9'd300, 9'd9};

  always #5 clk = ~clk;

  linear_probe_hash_table_core #(
    .SLOTS     (SLOTS),
    .KEY_BITS  (FIELD_BITS),
    .DATA_BITS (FIELD_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .key_in        (key_in),
    .hash_value    (hash_value),
    .data_in       (data_in),
    .table_size_we (table_size_we),
    .table_size    (table_size),
    .done          (done),
    .success       (success),
    .data_out      (data_out),
    .entry_count   (entry_count)
  );

  lpht_checker #(.SLOTS(SLOTS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .key_in        (key_in),
    .hash_value    (hash_value),
    .data_in       (data_in),
    .table_size_we (table_size_we),
    .table_size    (table_size),
    .done          (done),
    .success       (success),
    .data_out      (data_out),
    .entry_count   (entry_count),
    .fails         (fails),
    .pending       (pending)
  );

  // Watchdog: a hung probe or a lost done ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Present one request and hold it until the core takes it (start & !busy).
  // start stays high into the next request unless a gap is drawn, so each
  // step carries at most one update of start.
  task automatic send_request(input func_t op, input logic [FIELD_BITS-1:0] key,
                              input logic [HASH_BITS-1:0] hash,
                              input logic [FIELD_BITS-1:0] data);
    func       <= op;
    key_in     <= key;
    hash_value <= hash;
    data_in    <= data;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    if (op == FUNC_NOP) n_nop++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      // long gaps cover whole probes, short ones land mid-walk
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 60 : 6)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every transaction in flight has answered.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Register writes happen only with the core idle.
  task automatic write_table_size(input logic [SIZE_BITS-1:0] value);
    drain();
    table_size_we <= 1'b1;
    table_size    <= value;
    @(posedge clk);
    table_size_we <= 1'b0;
    n_sizes++;
  endtask

  task automatic fill_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = $urandom();
      // chain some keys onto the previous start slot so every size sees collisions
      if (i > 0 && $urandom_range(1) == 0) pool_hash[i] = pool_hash[i-1] + $urandom_range(1);
      else pool_hash[i] = $urandom();
    end
  endtask

  initial begin
    int    pick;
    int    sel;
    func_t op;
    rst           <= 1'b1;
    start         <= 1'b0;
    func          <= FUNC_NOP;
    key_in        <= '0;
    hash_value    <= '0;
    data_in       <= '0;
    table_size_we <= 1'b0;
    table_size    <= '0;
    gap_pct = 0;
    n_sent  = 0;
    n_nop   = 0;
    n_sizes = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // the clearing sweep keeps busy high; send_request simply waits it out

    // ---- directed: reset size 256, empty table
    send_request(FUNC_GET,    32'h0000_0005, 32'h0000_0000, 32'h0);        // miss, empty
    send_request(FUNC_REMOVE, 32'h0000_0005, 32'h0000_0000, 32'h0);        // miss, empty
    send_request(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF); // slot 0
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000); // slot 255
    send_request(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h1111_1111); // duplicate
    send_request(FUNC_INSERT, 32'hA5A5_A5A5, 32'h0000_0100, 32'h1234_5678); // collides -> 1
    send_request(FUNC_INSERT, 32'h5A5A_5A5A, 32'h0000_01FF, 32'h8765_4321); // wraps -> 2
    send_request(FUNC_GET,    32'hA5A5_A5A5, 32'h0000_0000, 32'hDEAD_BEEF);
    send_request(FUNC_GET,    32'h5A5A_5A5A, 32'h0000_00FF, 32'h0);
    send_request(FUNC_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // undefined op
    send_request(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0);
    // no tombstone: chains that ran through slot 0 are now cut
    send_request(FUNC_GET,    32'hA5A5_A5A5, 32'h0000_0000, 32'h0);
    send_request(FUNC_GET,    32'h5A5A_5A5A, 32'h0000_00FF, 32'h0);
    send_request(FUNC_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hCAFE_F00D);
    drain();

    // ---- size 1: one reachable slot, the rest stay counted
    write_table_size(9'd1);
    send_request(FUNC_GET,    32'h0000_0000, 32'h0000_3039, 32'h0);
    send_request(FUNC_INSERT, 32'h0000_0007, 32'h0000_0063, 32'h7777_7777); // full
    send_request(FUNC_REMOVE, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0);
    send_request(FUNC_INSERT, 32'h0000_0007, 32'h0000_0063, 32'h7777_7777);
    // ---- size 0 acts as 1
    write_table_size(9'd0);
    send_request(FUNC_GET,    32'h0000_0007, 32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_INSERT, 32'h0000_0008, 32'h8000_0000, 32'h0000_0008);
    // ---- 511 saturates to the full store
    write_table_size(9'd511);
    send_request(FUNC_GET,    32'hA5A5_A5A5, 32'h0000_0101, 32'h0);
    send_request(FUNC_INSERT, 32'h0000_0001, 32'hFFFF_FF00, 32'hAAAA_5555);

    // ---- random phases, one table size each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_table_size(phase_size[ph]);
      gap_pct = (ph < NUM_PHASES / 3) ? 26 : (ph < 2 * NUM_PHASES / 3) ? 50 : 0;
      fill_pool();
      for (int n = 0; n < PER_PHASE; n++) begin
        pick = $urandom_range(99);
        op = (pick < 40) ? FUNC_INSERT : (pick < 65) ? FUNC_REMOVE :
             (pick < 95) ? FUNC_GET : FUNC_NOP;
        sel = $urandom_range(POOL - 1);
        pick = $urandom_range(99);
        if (pick < 85)
          send_request(op, pool_key[sel], pool_hash[sel], $urandom());
        else if (pick < 92)  // known key, inconsistent hash
          send_request(op, pool_key[sel], $urandom(), $urandom());
        else                 // stray key
          send_request(op, $urandom(), $urandom(), $urandom());
      end
    end

    // ---- wind down: everything answered, then a tail for stray results
    drain();
    repeat (600) @(posedge clk);

    $display("Sent %0d requests (%0d undefined ops) over %0d table size settings,",
             n_sent, n_nop, n_sizes);
    $display("sizes 0 through 511 incl. full, wrapping and cut probe chains; %0d mismatches",
             fails);
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
